// ----- rtl/core/gbb_pkg.sv -----
// ----------------------------------------------------------------------------
// gbb_pkg - shared types and constants for the glyph bitmap blitter
// Field widths, command codes and the structs passed between the sequencer
// and the glyph store.
// ----------------------------------------------------------------------------
package gbb_pkg;

  localparam int GLYPH_DIM  = 24;  // rows and columns of one glyph
  localparam int HALF_DIM   = 12;  // rows and columns of a half-size glyph
  localparam int MAX_SLOTS  = 64;  // slots reachable by the 6-bit slot field

  localparam int SLOT_W  = 6;
  localparam int ROW_W   = 5;
  localparam int BITS_W  = 24;
  localparam int CP_W    = 21;
  localparam int COORD_W = 16;
  localparam int COLOR_W = 8;
  localparam int Y_W     = 17;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_FULL = 2'd1,
    CMD_HALF = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [ROW_W-1:0]   row_index;
    logic [BITS_W-1:0]  row_bits;
    logic [CP_W-1:0]    code_point;
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [COLOR_W-1:0] color;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [Y_W-1:0]     pixel_y;
    logic [COORD_W-1:0] pixel_x;
    logic [BITS_W-1:0]  pixel_mask;
    logic [COLOR_W-1:0] pixel_color;
    logic               last;
  } out_item_t;

  // Load request into the glyph store
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] slot;
    logic [ROW_W-1:0]  row;
    logic [BITS_W-1:0] bits;
    logic [CP_W-1:0]   tag;
  } wr_req_t;

  // Registered read data from the glyph store
  typedef struct packed {
    logic              valid;
    logic [CP_W-1:0]   tag;
    logic [BITS_W-1:0] row;
  } rd_data_t;

endpackage

// ----- rtl/core/gbb_store.sv -----
// ----------------------------------------------------------------------------
// gbb_store - glyph tag, valid and row storage
// One write port for loads; a tag/valid read port and a row read port, both
// with registered data.
// ----------------------------------------------------------------------------
module gbb_store #(
  parameter int SLOTS = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  gbb_pkg::wr_req_t                       wr,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] tag_raddr,
  input  logic [$clog2(SLOTS*gbb_pkg::GLYPH_DIM)-1:0]  row_raddr,
  output gbb_pkg::rd_data_t                      rd
);
  import gbb_pkg::*;

  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DEPTH = SLOTS * GLYPH_DIM;
  localparam int AW    = $clog2(DEPTH);

  logic [CP_W-1:0]   tag_mem [SLOTS];
  logic [BITS_W-1:0] row_mem [DEPTH];
  logic [SLOTS-1:0]  valid_r;

  logic              slot_ok;
  logic              row_ok;
  logic              wr_en;
  logic [SW-1:0]     wr_slot;
  logic [AW-1:0]     wr_addr;

  assign slot_ok = ({1'b0, wr.slot} < 7'(SLOTS));
  assign row_ok  = (wr.row < 5'(GLYPH_DIM));
  assign wr_en   = wr.we && slot_ok && row_ok;
  assign wr_slot = wr.slot[SW-1:0];
  // slot * 24 + row
  assign wr_addr = AW'({wr_slot, 4'b0000}) + AW'({wr_slot, 3'b000}) + AW'(wr.row);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_mem[wr_slot] <= wr.tag;
      row_mem[wr_addr] <= wr.bits;
    end
    rd.tag   <= tag_mem[tag_raddr];
    rd.valid <= valid_r[tag_raddr];
    rd.row   <= row_mem[row_raddr];
  end

endmodule

// ----- rtl/core/gbb_seq.sv -----
// ----------------------------------------------------------------------------
// gbb_seq - draw sequencer
// Scans slot tags through one comparator, then walks the glyph rows of the
// hit slot or flags a miss, filling the output register one result at a time.
// ----------------------------------------------------------------------------
module gbb_seq #(
  parameter int SLOTS = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [1:0]                             in_cmd,
  input  gbb_pkg::in_item_t                      in_item,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output gbb_pkg::out_item_t                     out_item,
  output gbb_pkg::wr_req_t                       wr,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] tag_raddr,
  output logic [$clog2(SLOTS*gbb_pkg::GLYPH_DIM)-1:0]  row_raddr,
  input  gbb_pkg::rd_data_t                      rd
);
  import gbb_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int AW = $clog2(SLOTS * GLYPH_DIM);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_MISS
  } state_t;

  state_t             state_r, state_nxt;
  logic [SW-1:0]      scan_r, scan_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [AW-1:0]      base_r, base_nxt;
  logic [BITS_W-1:0]  acc_r, acc_nxt;
  logic               half_r, half_nxt;
  logic [CP_W-1:0]    cp_r, cp_nxt;
  logic [COORD_W-1:0] ox_r, ox_nxt;
  logic [COORD_W-1:0] oy_r, oy_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  logic               can_load;
  logic               match;
  logic [ROW_W-1:0]   res_idx;
  logic               last_row;

  // OR each 2x2 block: two rows already merged, then adjacent column pairs
  function automatic logic [BITS_W-1:0] halve(input logic [BITS_W-1:0] r);
    logic [BITS_W-1:0] m;
    m = '0;
    for (int x = 0; x < HALF_DIM; x++) begin
      m[BITS_W-1-x] = r[BITS_W-1-2*x] | r[BITS_W-2-2*x];
    end
    return m;
  endfunction

  assign can_load = !out_valid_r || out_tready;
  assign match    = rd.valid && (rd.tag == cp_r);
  assign res_idx  = half_r ? (row_r >> 1) : row_r;
  assign last_row = (row_r == ROW_W'(GLYPH_DIM - 1));

  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    row_nxt       = row_r;
    base_nxt      = base_r;
    acc_nxt       = acc_r;
    half_nxt      = half_r;
    cp_nxt        = cp_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    color_nxt     = color_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_nxt       = out_r;
    in_tready     = 1'b0;
    wr            = '0;
    wr.slot       = in_item.slot;
    wr.row        = in_item.row_index;
    wr.bits       = in_item.row_bits;
    wr.tag        = in_item.code_point;

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (cmd_t'(in_cmd))
            CMD_LOAD: wr.we = 1'b1;
            CMD_FULL, CMD_HALF: begin
              half_nxt  = (cmd_t'(in_cmd) == CMD_HALF);
              cp_nxt    = in_item.code_point;
              ox_nxt    = in_item.origin_x;
              oy_nxt    = in_item.origin_y;
              color_nxt = in_item.color;
              scan_nxt  = '0;
              state_nxt = ST_SCAN;
            end
            CMD_NOP: ;
          endcase
        end
      end

      ST_SCAN: begin
        if (match) begin
          base_nxt  = AW'({scan_r, 4'b0000}) + AW'({scan_r, 3'b000});
          row_nxt   = '0;
          state_nxt = ST_EMIT;
        end else if (scan_r == SW'(SLOTS - 1)) begin
          state_nxt = ST_MISS;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end

      ST_EMIT: begin
        if (half_r && !row_r[0]) begin
          acc_nxt = rd.row;
          row_nxt = row_r + 1'b1;
        end else if (can_load) begin
          out_valid_nxt       = 1'b1;
          out_nxt.found       = 1'b1;
          out_nxt.pixel_y     = {oy_r[COORD_W-1], oy_r} + Y_W'(res_idx);
          out_nxt.pixel_x     = ox_r;
          out_nxt.pixel_mask  = half_r ? halve(acc_r | rd.row) : rd.row;
          out_nxt.pixel_color = color_r;
          out_nxt.last        = last_row;
          if (last_row) begin
            state_nxt = ST_IDLE;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end
      end

      ST_MISS: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          out_nxt.last  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  // read addresses follow the next-cycle pointers so data lines up with them
  assign tag_raddr = scan_nxt;
  assign row_raddr = base_nxt + AW'(row_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      scan_r      <= '0;
      row_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      scan_r      <= scan_nxt;
      row_r       <= row_nxt;
    end
    base_r  <= base_nxt;
    acc_r   <= acc_nxt;
    half_r  <= half_nxt;
    cp_r    <= cp_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    color_r <= color_nxt;
    out_r   <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_item   = out_r;

endmodule

// ----- rtl/core/glyph_bitmap_blitter_top.sv -----
// ----------------------------------------------------------------------------
// glyph_bitmap_blitter_top - 24x24 one-bit glyph table with row blitter
// Loads glyph rows into tagged slots and emits framebuffer row writes for
// full-size or half-size draws of a code point.
// ----------------------------------------------------------------------------
//  channel | direction | tdata / tuser / tlast
//  in_     | slave     | 96-bit item, tuser = command
//  out_    | master    | 72-bit row write, tuser = found, tlast = last
//
//  Load: accepted directly in the idle state, no result.
//  Draw: a tag scan (one tag compare per cycle), then a walk over the 24 rows
//  on the single row-memory read port (half size reads two rows per result);
//  a miss gives one result after the scan. Output stalls hold the row walk.
//  Reset clears the slot valid bits at once; tag and row memories are not
//  cleared. in_tready is low from draw acceptance until its last result is registered.
// ----------------------------------------------------------------------------
module glyph_bitmap_blitter_top #(
  parameter int GLYPH_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // slot, row_index, row_bits, code_point, origin_x, origin_y, color
  input  logic [95:0] in_tdata,
  // command
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // pixel_y, pixel_x, pixel_mask, pixel_color, zero fill
  output logic [71:0] out_tdata,
  // found
  output logic [0:0]  out_tuser,
  output logic        out_tlast
);
  import gbb_pkg::*;

  localparam int SLOTS = (GLYPH_SLOTS < MAX_SLOTS) ? GLYPH_SLOTS : MAX_SLOTS;
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int AW    = $clog2(SLOTS * GLYPH_DIM);

  in_item_t       in_item;
  out_item_t      out_item;
  wr_req_t        wr;
  rd_data_t       rd;
  logic [SW-1:0]  tag_raddr;
  logic [AW-1:0]  row_raddr;

  assign in_item.slot       = in_tdata[5:0];
  assign in_item.row_index  = in_tdata[10:6];
  assign in_item.row_bits   = in_tdata[34:11];
  assign in_item.code_point = in_tdata[55:35];
  assign in_item.origin_x   = in_tdata[71:56];
  assign in_item.origin_y   = in_tdata[87:72];
  assign in_item.color      = in_tdata[95:88];

  assign out_tdata = {7'b0, out_item.pixel_color, out_item.pixel_mask,
                      out_item.pixel_x, out_item.pixel_y};
  assign out_tuser = out_item.found;
  assign out_tlast = out_item.last;

  gbb_seq #(
    .SLOTS(SLOTS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_tuser),
    .in_item    (in_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_item   (out_item),
    .wr         (wr),
    .tag_raddr  (tag_raddr),
    .row_raddr  (row_raddr),
    .rd         (rd)
  );

  gbb_store #(
    .SLOTS(SLOTS)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .tag_raddr (tag_raddr),
    .row_raddr (row_raddr),
    .rd        (rd)
  );

endmodule
